FILE: hdl/fpms_pkg.sv
`default_nettype none
package fpms_pkg;

    // Default sizing
    localparam int NUM_STACKS_DEF  = 3;
    localparam int STACK_DEPTH_DEF = 16;

    // Field widths of the channels
    localparam int FUNC_W   = 2;
    localparam int SEL_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] OP_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_TOP  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WAIT
    } fpms_state_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
    } fpms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } fpms_stat_t;

endpackage
`default_nettype wire

FILE: hdl/fpms_req_if.sv
`default_nettype none
interface fpms_req_if;
    import fpms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [SEL_W-1:0]         stack_sel;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output func, output stack_sel, output push_value,
                    input ready);
    modport sink   (input valid, input func, input stack_sel, input push_value,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/fpms_rsp_if.sv
`default_nettype none
interface fpms_rsp_if;
    import fpms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic                     now_empty;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, output read_value, output status, output now_empty,
                    output fill_count, input ready);
    modport sink   (input valid, input read_value, input status, input now_empty,
                    input fill_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/fpms_ram.sv
`default_nettype none
module fpms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/fpms_ctrl.sv
`default_nettype none
module fpms_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fpms_pkg::fpms_stat_t st,
    output fpms_pkg::fpms_cmd_t       cmd
);
    import fpms_pkg::*;

    fpms_state_t state_reg;
    fpms_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: one item in flight, wait for the output register to free up
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            S_WAIT:
            begin
                cmd.load = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/fpms_dp.sv
`default_nettype none
module fpms_dp #(
    parameter int NUM_STACKS  = fpms_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = fpms_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpms_pkg::fpms_cmd_t  cmd,
    output fpms_pkg::fpms_stat_t      st,
    fpms_req_if.sink                  req,
    fpms_rsp_if.source                rsp
);
    import fpms_pkg::*;

    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int TOTAL = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    localparam logic [SW+1:0] SEL_LIMIT = (SW + 2)'(NUM_STACKS);
    localparam logic [CW-1:0] DEPTH_C   = CW'(STACK_DEPTH);

    // Per-stack fill counters
    logic [CW-1:0] fill_reg [NUM_STACKS];

    // Item held between accept and result load
    logic [STATUS_W-1:0] pend_status_reg;
    logic [CW-1:0]       pend_fill_reg;
    logic                pend_read_reg;

    // Output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] read_value_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic                     empty_reg;
    logic [FILL_W-1:0]        fill_out_reg;

    logic                accept;
    logic [SW+1:0]       sel_ext;
    logic                sel_ok;
    logic [SW-1:0]       idx;
    logic [CW-1:0]       cur_fill;
    logic                is_push;
    logic                is_rd_op;
    logic                do_push;
    logic                do_read;
    logic                do_pop;
    logic [CW-1:0]       new_fill;
    logic [STATUS_W-1:0] new_status;
    logic [AW-1:0]       base;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [DATA_W-1:0]   ram_rd;
    logic [CW+FILL_W-1:0] fill_wide;

    assign accept = req.valid & cmd.in_ready;

    assign sel_ext  = {{SW{1'b0}}, req.stack_sel};
    assign sel_ok   = sel_ext < SEL_LIMIT;
    assign idx      = sel_ext[SW-1:0];
    assign cur_fill = sel_ok ? fill_reg[idx] : '0;

    assign is_push  = req.func == OP_PUSH;
    assign is_rd_op = (req.func == OP_POP) || (req.func == OP_TOP);
    assign do_push  = sel_ok & is_push & (cur_fill != DEPTH_C);
    assign do_read  = sel_ok & is_rd_op & (cur_fill != '0);
    assign do_pop   = do_read & (req.func == OP_POP);

    always_comb
    begin
        new_fill = cur_fill;
        if (do_push)
        begin
            new_fill = cur_fill + CW'(1);
        end
        else if (do_pop)
        begin
            new_fill = cur_fill - CW'(1);
        end
    end

    always_comb
    begin
        new_status = STAT_OK;
        if (is_push && !do_push)
        begin
            new_status = STAT_FULL;
        end
        else if (is_rd_op && !do_read)
        begin
            new_status = STAT_EMPTY;
        end
    end

    // Slice base: stack number times the per-stack depth
    assign base    = AW'(idx * STACK_DEPTH);
    assign wr_addr = base + AW'(cur_fill);
    assign rd_addr = base + AW'(cur_fill - CW'(1));

    fpms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept & do_push),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (accept & do_read),
        .rd_addr (rd_addr),
        .rd_data (ram_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (accept && (do_push || do_pop))
        begin
            fill_reg[idx] <= new_fill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= new_status;
            pend_fill_reg   <= new_fill;
            pend_read_reg   <= do_read;
        end
    end

    assign out_valid_next = cmd.load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Report the low five bits of the count
    assign fill_wide = {{FILL_W{1'b0}}, pend_fill_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_value_reg <= pend_read_reg ? ram_rd : '0;
            status_reg     <= pend_status_reg;
            empty_reg      <= pend_fill_reg == '0;
            fill_out_reg   <= fill_wide[FILL_W-1:0];
        end
    end

    assign req.ready      = cmd.in_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.now_empty  = empty_reg;
    assign rsp.fill_count = fill_out_reg;

    assign st.in_valid = req.valid;
    assign st.out_free = !out_valid_reg || rsp.ready;
endmodule
`default_nettype wire

FILE: hdl/fixed_partition_multi_stack.sv
`default_nettype none
// Flow: an accepted item waits in the pending registers while the two-state sequencer is in
//   its wait state, then loads into the result register once that register is free; no new
//   item is taken before that load. The registered memory read lands in the result with it.
//   A new item is taken while the previous result still waits.
// Reset (rst_n, asynchronous, active low): fill counters, controller and output valid
//   clear at once; the shared memory is not cleared and needs no clearing pass.
module fixed_partition_multi_stack #(
    parameter int NUM_STACKS  = fpms_pkg::NUM_STACKS_DEF,
    parameter int STACK_DEPTH = fpms_pkg::STACK_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fpms_req_if.sink   req,
    fpms_rsp_if.source rsp
);
    import fpms_pkg::*;

    // Command and status between sequencer and datapath
    fpms_cmd_t  ctl_cmd;
    fpms_stat_t ctl_st;

    // Sequencer: take one transfer, then hold until the result register frees
    fpms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (ctl_st),
        .cmd   (ctl_cmd)
    );

    // Datapath: fill counters, shared memory, pending item and result register.
    // Push writes and pop/top reads are issued in the transfer cycle; the read
    // word comes back registered in the next cycle and lands in the result.
    fpms_dp #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ctl_cmd),
        .st    (ctl_st),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef SYNTH
    // One item at a time: no back-to-back input transfers
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("input taken while an item was in flight");

    // Any error result carries a zero data word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STAT_OK) |-> (rsp.read_value == '0))
        else $error("error result with nonzero data");

    // A nonzero count never comes with the empty flag
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.fill_count != '0) |-> !rsp.now_empty)
        else $error("empty flag set with nonzero fill");

    // A result only loads into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> !$past(ctl_cmd.load))
        else $error("result loaded over a waiting result");
`endif
endmodule
`default_nettype wire
